FILE: rtl/core/crpe_pkg.sv
// Shared types, constants and widths for the Catmull-Rom point evaluator.
package crpe_pkg;

   localparam int MAX_POINTS = 64;
   localparam int FRAC_BITS  = 16;

   localparam int PIDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int CSR_W   = 7;
   localparam int IDX_W   = 6;
   localparam int T_W     = FRAC_BITS + 1;
   localparam int PROG_W  = T_W + PIDX_W;
   localparam int COORD_W = 32;
   localparam int PT_W    = 3 * COORD_W;
   localparam int COEF_W  = COORD_W + 4;
   localparam int PROD_W  = COEF_W + T_W + 1;
   localparam int ACC_W   = PROD_W + 2;
   localparam int NUM_TAPS = 4;
   localparam int NSTG    = 6;

   localparam logic [T_W-1:0] ONE_T = T_W'(1) << FRAC_BITS;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic [IDX_W-1:0]          point_index;
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
      logic [T_W-1:0]            param_t;
   } crpe_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
   } crpe_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } crpe_point_type;

   typedef struct packed {
      logic valid;
      logic empty;
   } crpe_ctl_type;

   typedef struct packed {
      logic [PIDX_W-1:0] i0;
      logic [PIDX_W-1:0] i1;
      logic [PIDX_W-1:0] i2;
      logic [PIDX_W-1:0] i3;
      logic [T_W-1:0]    frac_t;
   } crpe_fetch_type;

endpackage

FILE: rtl/core/catmull_rom_point_eval_core.sv
// Uniform Catmull-Rom curve evaluator over a table of 3-D control points.
//
// Usage:
//   csr_we/csr_wdata set point_count (points in use); write it only while idle.
//   A transaction is taken when start is high and busy is low. kind = load
//   writes one point into the table and gives no result. kind = eval maps
//   param_t (Q1.16, clamped to 1.0) onto the curve and gives one point.
//   Results appear on rsp_data with rsp_valid high for exactly one cycle;
//   the receiver cannot stall, so there is no back-pressure path.
// Timing:
//   One transaction per clock, loads and evaluates freely mixed.
//   rsp_valid rises once the result has passed the registered stages: one stage
//   scales t, one reads the four replicated point RAMs, then t powers and
//   coefficients, products, sum, saturation and the output register.
//   A load is visible to an evaluate accepted on the next cycle.
// Reset:
//   busy is high during reset; point_count clears to 0 and the pipeline
//   empties. Table contents are kept undefined until loaded.
module catmull_rom_point_eval_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  crpe_pkg::crpe_req_type        req_data,
   output logic                          rsp_valid,
   output crpe_pkg::crpe_rsp_type        rsp_data,
   input  logic                          csr_we,
   input  logic [crpe_pkg::CSR_W-1:0]    csr_wdata
);
   import crpe_pkg::*;

   logic [CSR_W-1:0]  count_ff;
   logic              accept;
   logic              wr_en;
   logic [T_W-1:0]    t_clamp;
   logic [CNT_W-1:0]  n_in, n_ff;
   logic [PIDX_W-1:0] sec_in;
   logic [PROG_W-1:0] prog_in, prog_ff;
   crpe_ctl_type      ctl_in;
   crpe_ctl_type      ctl_ff [1:NSTG];
   crpe_fetch_type    fetch;
   logic [PIDX_W-1:0] rd_addr [NUM_TAPS];
   logic [PT_W-1:0]   rd_word [NUM_TAPS];
   crpe_point_type    rd_pt   [NUM_TAPS];
   logic [T_W-1:0]    frac2_ff, frac3_ff, frac4_ff;
   logic [2*T_W-1:0]  sq_in, cube_in;
   logic [T_W-1:0]    lt2_3_ff, lt2_4_ff, lt3_4_ff;
   logic signed [COORD_W-1:0] res_x, res_y, res_z;
   logic              rsp_valid_ff;
   crpe_rsp_type      rsp_data_in, rsp_data_ff;

   assign busy   = reset;
   assign accept = start && !busy;
   assign wr_en  = accept && (req_data.kind == KIND_LOAD)
                   && (int'(req_data.point_index) < MAX_POINTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // stage 0: clamp t and point count, scale t by the section count
   always_comb begin
      t_clamp = (req_data.param_t > ONE_T) ? ONE_T : req_data.param_t;
      if (int'(count_ff) > MAX_POINTS) begin
         n_in = CNT_W'(MAX_POINTS);
      end else begin
         n_in = CNT_W'(count_ff);
      end
      sec_in       = PIDX_W'(n_in - CNT_W'(1));
      prog_in      = PROG_W'(t_clamp) * PROG_W'(sec_in);
      ctl_in.valid = accept && (req_data.kind == KIND_EVAL);
      ctl_in.empty = (n_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= NSTG; i++) begin
            ctl_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff[1] <= ctl_in;
         for (int i = 2; i <= NSTG; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
         rsp_valid_ff <= ctl_ff[NSTG].valid;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      prog_ff <= prog_in;
   end

   // stage 1: segment and tap addresses
   crpe_seg u_seg (
      .n        (n_ff),
      .progress (prog_ff),
      .fetch    (fetch)
   );

   assign rd_addr[0] = fetch.i0;
   assign rd_addr[1] = fetch.i1;
   assign rd_addr[2] = fetch.i2;
   assign rd_addr[3] = fetch.i3;

   for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
      crpe_ram #(
         .WIDTH (PT_W),
         .DEPTH (MAX_POINTS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (PIDX_W'(req_data.point_index)),
         .wr_data ({req_data.in_x, req_data.in_y, req_data.in_z}),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_word[g])
      );
      assign rd_pt[g] = crpe_point_type'(rd_word[g]);
   end

   // stages 2..3: powers of local t
   always_comb begin
      sq_in   = (2*T_W)'(frac2_ff) * (2*T_W)'(frac2_ff);
      cube_in = (2*T_W)'(lt2_3_ff) * (2*T_W)'(frac3_ff);
   end

   always_ff @(posedge clock) begin
      frac2_ff <= fetch.frac_t;
      frac3_ff <= frac2_ff;
      lt2_3_ff <= sq_in[FRAC_BITS +: T_W];
      frac4_ff <= frac3_ff;
      lt2_4_ff <= lt2_3_ff;
      lt3_4_ff <= cube_in[FRAC_BITS +: T_W];
   end

   crpe_blend u_blend_x (
      .clock (clock),
      .p0 (rd_pt[0].x), .p1 (rd_pt[1].x), .p2 (rd_pt[2].x), .p3 (rd_pt[3].x),
      .t1 (frac4_ff), .t2 (lt2_4_ff), .t3 (lt3_4_ff),
      .result (res_x)
   );

   crpe_blend u_blend_y (
      .clock (clock),
      .p0 (rd_pt[0].y), .p1 (rd_pt[1].y), .p2 (rd_pt[2].y), .p3 (rd_pt[3].y),
      .t1 (frac4_ff), .t2 (lt2_4_ff), .t3 (lt3_4_ff),
      .result (res_y)
   );

   crpe_blend u_blend_z (
      .clock (clock),
      .p0 (rd_pt[0].z), .p1 (rd_pt[1].z), .p2 (rd_pt[2].z), .p3 (rd_pt[3].z),
      .t1 (frac4_ff), .t2 (lt2_4_ff), .t3 (lt3_4_ff),
      .result (res_z)
   );

   always_comb begin
      if (ctl_ff[NSTG].empty) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in.out_x = res_x;
         rsp_data_in.out_y = res_y;
         rsp_data_in.out_z = res_z;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_eval_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == KIND_EVAL) |-> ##(NSTG + 1) rsp_valid)
      else $error("evaluate transaction lost in pipeline");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && req_data.kind == KIND_EVAL, NSTG + 1))
      else $error("result without evaluate transaction");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff[NSTG].valid && ctl_ff[NSTG].empty) |=> (rsp_valid && rsp_data == '0))
      else $error("empty table did not give zero");
`endif

endmodule

FILE: rtl/core/crpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/crpe_seg.sv
// Segment select: splits scaled t into segment and local t, forms the four taps.
module crpe_seg (
   input  logic [crpe_pkg::CNT_W-1:0]  n,
   input  logic [crpe_pkg::PROG_W-1:0] progress,
   output crpe_pkg::crpe_fetch_type    fetch
);
   import crpe_pkg::*;

   logic [PIDX_W-1:0]   sections;
   logic [PIDX_W:0]     seg_raw;
   logic [PIDX_W-1:0]   seg;
   logic [PROG_W-1:0]   seg_base;
   logic [CNT_W:0]      seg_plus2;

   always_comb begin
      sections  = PIDX_W'(n - CNT_W'(1));
      seg_raw   = progress[PROG_W-1:FRAC_BITS];
      if (seg_raw >= {1'b0, sections}) begin
         seg = sections - PIDX_W'(1);
      end else begin
         seg = seg_raw[PIDX_W-1:0];
      end
      seg_base  = PROG_W'({seg, FRAC_BITS'(0)});
      seg_plus2 = (CNT_W+1)'(seg) + (CNT_W+1)'(2);

      if (n <= CNT_W'(1)) begin
         fetch = '0;
      end else begin
         fetch.i1     = seg;
         fetch.i2     = seg + PIDX_W'(1);
         fetch.i0     = (seg == '0) ? seg : seg - PIDX_W'(1);
         fetch.i3     = (seg_plus2 >= (CNT_W+1)'(n)) ? seg + PIDX_W'(1)
                                                      : seg + PIDX_W'(2);
         fetch.frac_t = T_W'(progress - seg_base);
      end
   end

endmodule

FILE: rtl/core/crpe_blend.sv
// One axis of the Catmull-Rom blend: coefficients, products, sum, saturation.
module crpe_blend (
   input  logic                                 clock,
   input  logic signed [crpe_pkg::COORD_W-1:0]  p0,
   input  logic signed [crpe_pkg::COORD_W-1:0]  p1,
   input  logic signed [crpe_pkg::COORD_W-1:0]  p2,
   input  logic signed [crpe_pkg::COORD_W-1:0]  p3,
   input  logic [crpe_pkg::T_W-1:0]             t1,
   input  logic [crpe_pkg::T_W-1:0]             t2,
   input  logic [crpe_pkg::T_W-1:0]             t3,
   output logic signed [crpe_pkg::COORD_W-1:0]  result
);
   import crpe_pkg::*;

   logic signed [COEF_W-1:0] e0, e1, e2, e3;
   logic signed [COEF_W-1:0] c1_in, c2_in, c3_in;
   logic signed [COEF_W-1:0] c1_ff, c2_ff, c3_ff;
   logic signed [COEF_W-1:0] c1d_ff, c2d_ff, c3d_ff;
   logic signed [ACC_W-1:0]  base_in, base_ff, based_ff, base2_ff;
   logic signed [T_W:0]      s1, s2, s3;
   logic signed [PROD_W-1:0] m1_in, m2_in, m3_in;
   logic signed [PROD_W-1:0] m1_ff, m2_ff, m3_ff;
   logic signed [ACC_W-1:0]  acc_in, acc_ff;
   logic signed [ACC_W-1:0]  shifted;

   always_comb begin
      e0 = COEF_W'(p0);
      e1 = COEF_W'(p1);
      e2 = COEF_W'(p2);
      e3 = COEF_W'(p3);
      c1_in   = e2 - e0;
      c2_in   = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c3_in   = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
      base_in = ACC_W'(p1) <<< (FRAC_BITS + 1);
   end

   always_comb begin
      s1 = $signed({1'b0, t1});
      s2 = $signed({1'b0, t2});
      s3 = $signed({1'b0, t3});
      m1_in = PROD_W'(c1d_ff) * PROD_W'(s1);
      m2_in = PROD_W'(c2d_ff) * PROD_W'(s2);
      m3_in = PROD_W'(c3d_ff) * PROD_W'(s3);
      acc_in = ACC_W'(m1_ff) + ACC_W'(m2_ff) + ACC_W'(m3_ff) + base2_ff;
   end

   always_ff @(posedge clock) begin
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      c3_ff    <= c3_in;
      base_ff  <= base_in;
      c1d_ff   <= c1_ff;
      c2d_ff   <= c2_ff;
      c3d_ff   <= c3_ff;
      based_ff <= base_ff;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      m3_ff    <= m3_in;
      base2_ff <= based_ff;
      acc_ff   <= acc_in;
   end

   // arithmetic shift takes the one half with the Q scaling; then saturate
   always_comb begin
      shifted = acc_ff >>> (FRAC_BITS + 1);
      if (shifted[ACC_W-1:COORD_W-1] == '0 || shifted[ACC_W-1:COORD_W-1] == '1) begin
         result = shifted[COORD_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         result = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

endmodule
